/* rtl/core/ssa_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// ssa_pkg
// Shared types and constants for the sparse scatter-accumulate block.
// ============================================================================
package ssa_pkg;

  // Fixed field widths
  localparam int IDX_W     = 12;  // target index
  localparam int IN_W      = 16;  // Q1.15 weight and rate
  localparam int VAL_W     = 32;  // Q15.16 write value and entry read back
  localparam int PROD_W    = 2 * IN_W;
  localparam int PROD_SHIFT = 14; // Q2.30 -> Q15.16

  // Request codes
  localparam logic [1:0] REQ_ACC   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Stage-1 control handed to the update unit
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       in_range;
    logic       row_end;
  } upd_ctrl_t;

  // Decisions coming back from the update unit
  typedef struct packed {
    logic wr_en;
    logic set_sat;
    logic emit;
    logic row_done;
  } upd_res_t;

endpackage

/* rtl/core/ssa_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// ssa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first: a read and a write to the same entry return the old data.
// ============================================================================
module ssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/ssa_update.sv */
`timescale 1ns / 1ps
// ============================================================================
// ssa_update
// Modify step of the read-modify-write: scaled product add with saturation,
// clamped entry load, and the read-back value of a result.
// ============================================================================
module ssa_update #(
  parameter int ACC_WIDTH = 32
) (
  input  ssa_pkg::upd_ctrl_t              ctrl,
  input  logic signed [ACC_WIDTH-1:0]     old_value,
  input  logic signed [ssa_pkg::PROD_W-1:0] product,
  input  logic signed [ssa_pkg::VAL_W-1:0]  write_value,
  output ssa_pkg::upd_res_t               res,
  output logic signed [ACC_WIDTH-1:0]     new_value,
  output logic signed [ssa_pkg::VAL_W-1:0]  entry_value
);
  import ssa_pkg::*;

  localparam int CW = PROD_W - PROD_SHIFT;                       // contribution
  localparam int SW = ((ACC_WIDTH > CW) ? ACC_WIDTH : CW) + 1;   // sum
  localparam int WW = (ACC_WIDTH > VAL_W) ? ACC_WIDTH : VAL_W;   // common wide
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [VAL_W-1:0]     OUT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0]     OUT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic signed [CW-1:0]        contrib;
  logic signed [SW-1:0]        sum;
  logic                        sum_ovf;
  logic [ACC_WIDTH-1:0]        sum_sat;
  logic signed [WW-1:0]        wr_ext;
  logic                        wr_ovf;
  logic [ACC_WIDTH-1:0]        wr_sat;
  logic signed [ACC_WIDTH-1:0] shown;
  logic signed [WW-1:0]        shown_ext;
  logic                        out_ovf;

  // arithmetic shift right = floor division by 2^14
  assign contrib = product[PROD_W-1:PROD_SHIFT];
  assign sum     = SW'(old_value) + SW'(contrib);
  assign sum_ovf = !((&sum[SW-1:ACC_WIDTH-1]) || !(|sum[SW-1:ACC_WIDTH-1]));
  assign sum_sat = sum_ovf ? (sum[SW-1] ? ACC_MIN : ACC_MAX) : sum[ACC_WIDTH-1:0];

  assign wr_ext  = WW'(write_value);
  assign wr_ovf  = !((&wr_ext[WW-1:ACC_WIDTH-1]) || !(|wr_ext[WW-1:ACC_WIDTH-1]));
  assign wr_sat  = wr_ovf ? (wr_ext[WW-1] ? ACC_MIN : ACC_MAX) : wr_ext[ACC_WIDTH-1:0];

  always_comb begin
    res       = '0;
    new_value = sum_sat;
    shown     = '0;
    case (ctrl.kind)
      REQ_ACC: begin
        res.wr_en    = ctrl.valid && ctrl.in_range;
        res.set_sat  = ctrl.valid && ctrl.in_range && sum_ovf;
        res.emit     = ctrl.valid && ctrl.row_end;
        res.row_done = 1'b1;
        shown        = ctrl.in_range ? sum_sat : '0;
      end
      REQ_READ: begin
        res.emit = ctrl.valid;
        shown    = ctrl.in_range ? old_value : '0;
      end
      REQ_WRITE: begin
        res.wr_en = ctrl.valid && ctrl.in_range;
        new_value = wr_sat;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // wide accumulators are clamped to 32 bits on read-back
  assign shown_ext   = WW'(shown);
  assign out_ovf     = !((&shown_ext[WW-1:VAL_W-1]) || !(|shown_ext[WW-1:VAL_W-1]));
  assign entry_value = out_ovf ? (shown_ext[WW-1] ? OUT_MIN : OUT_MAX)
                               : shown_ext[VAL_W-1:0];

endmodule

/* rtl/core/sparse_scatter_accumulate_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// sparse_scatter_accumulate_top
// Scatter-add of weighted synapse contributions into an accumulator memory.
// ============================================================================
// After reset the block runs a clearing pass that zeroes the accumulator
// memory one entry per cycle: busy stays high up to the last entry and no
// item is taken. From then on busy is low and the block takes one item per
// clock (start high, busy low is a transfer) for any mix of accumulates,
// reads and writes, including back-to-back hits on the same entry. Each
// result (a read, or an accumulate that closes a row) shows on the out_
// ports for exactly one cycle with out_valid, once its item has passed
// stage 1 and the output register, in item order. The receiver cannot
// hold results off and need not: at most one result leaves per cycle.
//
// Rate: one item per cycle, set by the read-modify-write loop on the
// accumulator RAM (read issued at transfer, add/saturate and write-back
// in the next cycle, last written entry forwarded to the following item).
// Datapath: weight * rate (Q2.30) is registered at transfer, shifted to
// Q15.16 with floor rounding, added to the entry and clamped to the signed
// ACC_WIDTH range; a clamp sets a sticky flag reported with every result.
// Out-of-range indexes change nothing and read back as zero.
// ============================================================================
module sparse_scatter_accumulate_top #(
  parameter int NUM_OUTPUTS = 4096,
  parameter int ACC_WIDTH   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_req_type,
  input  logic [ssa_pkg::IDX_W-1:0]         in_target_index,
  input  logic signed [ssa_pkg::IN_W-1:0]   in_weight,
  input  logic signed [ssa_pkg::IN_W-1:0]   in_rate,
  input  logic signed [ssa_pkg::VAL_W-1:0]  in_write_value,
  input  logic                              in_row_end,
  output logic                              out_valid,
  output logic signed [ssa_pkg::VAL_W-1:0]  out_entry_value,
  output logic                              out_saturated_seen,
  output logic                              out_row_done
);
  import ssa_pkg::*;

  localparam int AW = $clog2(NUM_OUTPUTS);
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_OUTPUTS - 1);

  // clearing pass
  logic          clearing_r, clearing_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // transfer and index decode
  logic          accept;
  logic [XW-1:0] idx_ext;
  logic          idx_in_range;
  logic [AW-1:0] rd_addr;

  // stage 1 (modify and write back)
  logic                       s1_valid_r;
  logic [1:0]                 s1_kind_r;
  logic                       s1_in_range_r;
  logic                       s1_row_end_r;
  logic [AW-1:0]              s1_addr_r;
  logic signed [PROD_W-1:0]   s1_prod_r;
  logic signed [VAL_W-1:0]    s1_wval_r;

  // forwarding of the entry written in the previous cycle
  logic                       fwd_v_r;
  logic [AW-1:0]              fwd_addr_r;
  logic [ACC_WIDTH-1:0]       fwd_val_r;

  logic                       sat_r;

  // output register
  logic                       out_valid_r;
  logic signed [VAL_W-1:0]    out_value_r;
  logic                       out_sat_r;
  logic                       out_done_r;

  upd_ctrl_t                  upd_ctrl;
  upd_res_t                   upd_res;
  logic [ACC_WIDTH-1:0]       ram_rdata;
  logic signed [ACC_WIDTH-1:0] old_value;
  logic signed [ACC_WIDTH-1:0] new_value;
  logic signed [VAL_W-1:0]    entry_value;
  logic                       set_sat;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ACC_WIDTH-1:0]       ram_wdata;

  assign busy   = clearing_r;
  assign accept = start && !busy;

  assign idx_ext      = XW'(in_target_index);
  assign idx_in_range = ({1'b0, idx_ext} < (XW + 1)'(NUM_OUTPUTS));
  assign rd_addr      = idx_ext[AW-1:0];

  // sweep one entry per cycle after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // accumulator memory
  assign ram_we    = clearing_r || upd_res.wr_en;
  assign ram_waddr = clearing_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clearing_r ? '0 : new_value;

  ssa_ram #(
    .WIDTH (ACC_WIDTH),
    .DEPTH (NUM_OUTPUTS)
  ) u_accum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // stage 1 payload, product registered before the add
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r     <= in_req_type;
      s1_in_range_r <= idx_in_range;
      s1_row_end_r  <= in_row_end;
      s1_addr_r     <= rd_addr;
      s1_prod_r     <= in_weight * in_rate;
      s1_wval_r     <= in_write_value;
    end
  end

  // RAM read missed a write landing on the same edge: take it from here
  assign old_value = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_val_r : ram_rdata;

  assign upd_ctrl.valid    = s1_valid_r;
  assign upd_ctrl.kind     = s1_kind_r;
  assign upd_ctrl.in_range = s1_in_range_r;
  assign upd_ctrl.row_end  = s1_row_end_r;

  ssa_update #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_update (
    .ctrl        (upd_ctrl),
    .old_value   (old_value),
    .product     (s1_prod_r),
    .write_value (s1_wval_r),
    .res         (upd_res),
    .new_value   (new_value),
    .entry_value (entry_value)
  );

  assign set_sat = sat_r || upd_res.set_sat;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_v_r     <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      fwd_v_r     <= upd_res.wr_en;
      sat_r       <= set_sat;
      out_valid_r <= upd_res.emit;
    end
  end

  // forward and output payload
  always_ff @(posedge clk) begin
    fwd_addr_r  <= s1_addr_r;
    fwd_val_r   <= new_value;
    out_value_r <= entry_value;
    out_sat_r   <= set_sat;
    out_done_r  <= upd_res.row_done;
  end

  assign out_valid          = out_valid_r;
  assign out_entry_value    = out_value_r;
  assign out_saturated_seen = out_sat_r;
  assign out_row_done       = out_done_r;

endmodule

/* rtl/core/ssa_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// ssa_checker
// Port-level checks on the scatter-accumulate top, bound to every instance.
// ============================================================================
module ssa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic [1:0]                       in_req_type,
  input logic                             in_row_end,
  input logic                             out_valid,
  input logic                             out_saturated_seen,
  input logic                             out_row_done
);
  import ssa_pkg::*;

  logic [1:0] settle_r;
  logic       sat_seen_r;

  // cycles since reset release, so $past never reaches before reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r   <= '0;
      sat_seen_r <= 1'b0;
    end else begin
      if (settle_r != 2'd3) begin
        settle_r <= settle_r + 1'b1;
      end
      if (out_valid && out_saturated_seen) begin
        sat_seen_r <= 1'b1;
      end
    end
  end

  // clearing pass holds off transfers right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    disable iff (!rst_n) (settle_r == 2'd0) |-> busy)
    else $error("busy low right after reset");

  // a row-done result comes from a taken accumulate with row end
  a_row_done_src: assert property (@(posedge clk)
    disable iff (!rst_n) (settle_r == 2'd3 && out_valid && out_row_done) |->
      $past(start && !busy && in_req_type == REQ_ACC && in_row_end, 2))
    else $error("row done without matching accumulate");

  // any other result comes from a taken read
  a_read_src: assert property (@(posedge clk)
    disable iff (!rst_n) (settle_r == 2'd3 && out_valid && !out_row_done) |->
      $past(start && !busy && in_req_type == REQ_READ, 2))
    else $error("read result without matching read");

  // saturation flag never drops once reported
  a_sat_sticky: assert property (@(posedge clk)
    disable iff (!rst_n) (out_valid && sat_seen_r) |-> out_saturated_seen)
    else $error("saturation flag cleared");

endmodule

bind sparse_scatter_accumulate_top ssa_checker u_ssa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_req_type        (in_req_type),
  .in_row_end         (in_row_end),
  .out_valid          (out_valid),
  .out_saturated_seen (out_saturated_seen),
  .out_row_done       (out_row_done)
);

/* dv/sparse_scatter_accumulate_top_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// sparse_scatter_accumulate_top_test
// Self-checking bench for the sparse scatter-accumulate block: directed
// corner cases, then row-shaped random traffic, each phase setting its
// amount of idling on the command side, all results checked in order.
// ============================================================================
module sparse_scatter_accumulate_top_test;
  import ssa_pkg::*;

  // Block configuration (defaults of the top level)
  localparam int NUM_OUT = 4096;
  localparam int ACC_W   = 32;

  localparam longint ACC_MAX = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;

  // Request code the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Clearing pass plus ~750 transfers, each with a sender gap capped at
  // MAX_GAP, then taken several times over.
  localparam int MAX_GAP     = 40;
  localparam int DRAIN_PAUSE = 8;
  localparam int CYCLE_LIMIT = 400000;

  // Expected result of one read or row-closing accumulate
  typedef struct packed {
    logic signed [VAL_W-1:0] entry_value;
    logic                    saturated_seen;
    logic                    row_done;
  } entry_result_t;

  logic                     clk   = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_req_type     = REQ_ACC;
  logic [IDX_W-1:0]         in_target_index = '0;
  logic signed [IN_W-1:0]   in_weight       = '0;
  logic signed [IN_W-1:0]   in_rate         = '0;
  logic signed [VAL_W-1:0]  in_write_value  = '0;
  logic                     in_row_end      = 1'b0;
  logic                     out_valid;
  logic signed [VAL_W-1:0]  out_entry_value;
  logic                     out_saturated_seen;
  logic                     out_row_done;

  // Shadow copy of the accumulator memory and the sticky flag
  longint        entry_mem [NUM_OUT];
  bit            sat_flag;
  entry_result_t pending_results [$];

  logic [IDX_W-1:0] hot_idx [8];   // small working set, gives repeated hits
  int idle_pct;                    // chance per cycle that the sender idles
  int error_count     = 0;
  int items_sent;
  int results_checked = 0;
  int rows_closed     = 0;
  int cycle_count     = 0;

  sparse_scatter_accumulate_top #(
    .NUM_OUTPUTS (NUM_OUT),
    .ACC_WIDTH   (ACC_W)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_target_index    (in_target_index),
    .in_weight          (in_weight),
    .in_rate            (in_rate),
    .in_write_value     (in_write_value),
    .in_row_end         (in_row_end),
    .out_valid          (out_valid),
    .out_entry_value    (out_entry_value),
    .out_saturated_seen (out_saturated_seen),
    .out_row_done       (out_row_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp_acc(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // Results report the entry clamped to 32 bits plus the flag after the item
  function automatic entry_result_t make_result(input longint v, input bit done);
    entry_result_t res;
    if (v > VAL_MAX) v = VAL_MAX;
    if (v < VAL_MIN) v = VAL_MIN;
    res.entry_value    = v[VAL_W-1:0];
    res.saturated_seen = sat_flag;
    res.row_done       = done;
    return res;
  endfunction

  // Applies one transferred item to the shadow state and queues the result
  // it causes, if any.
  task automatic apply_item(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                            input logic signed [IN_W-1:0] w,
                            input logic signed [IN_W-1:0] r,
                            input logic signed [VAL_W-1:0] wval, input logic re);
    longint cur;
    longint sum;
    bit     in_range;
    in_range = (idx < NUM_OUT);
    cur      = in_range ? entry_mem[idx] : 0;
    case (kind)
      REQ_ACC: begin
        if (in_range) begin
          // Q2.30 product to Q15.16; arithmetic shift rounds toward -inf
          sum = cur + ((longint'(w) * longint'(r)) >>> PROD_SHIFT);
          if (sum > ACC_MAX || sum < ACC_MIN) begin
            sum      = clamp_acc(sum);
            sat_flag = 1'b1;
          end
          entry_mem[idx] = sum;
          cur            = sum;
        end
        if (re) pending_results.push_back(make_result(cur, 1'b1));
      end
      REQ_READ: begin
        pending_results.push_back(make_result(cur, 1'b0));
      end
      REQ_WRITE: begin
        if (in_range) entry_mem[idx] = clamp_acc(longint'(wval));
      end
      default: ;  // unused code: no effect, no result
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every strobed result is a transfer, checked against the
  // oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    entry_result_t exp_res;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: entry_value %0d, row_done %0b",
               out_entry_value, out_row_done);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (out_row_done === 1'b1) rows_closed++;
        if (out_entry_value !== exp_res.entry_value) begin
          $error("out_entry_value: expected %0d, got %0d",
                 exp_res.entry_value, out_entry_value);
          error_count++;
        end
        if (out_saturated_seen !== exp_res.saturated_seen) begin
          $error("out_saturated_seen: expected %0b, got %0b",
                 exp_res.saturated_seen, out_saturated_seen);
          error_count++;
        end
        if (out_row_done !== exp_res.row_done) begin
          $error("out_row_done: expected %0b, got %0b",
                 exp_res.row_done, out_row_done);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Drives one item and holds it until a transfer (start high, busy low at an
  // edge). start is left high afterwards so back-to-back items never lower
  // and raise it in one step; a gap lowers it at the start of the next call.
  task automatic send_item(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                           input logic signed [IN_W-1:0] w,
                           input logic signed [IN_W-1:0] r,
                           input logic signed [VAL_W-1:0] wval, input logic re);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      // Garbage on the fields while start is low must be ignored
      start           <= 1'b0;
      in_req_type     <= 2'($urandom_range(3));
      in_target_index <= IDX_W'($urandom);
      in_weight       <= IN_W'($urandom);
      in_rate         <= IN_W'($urandom);
      in_write_value  <= $urandom;
      in_row_end      <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_req_type     <= kind;
    in_target_index <= idx;
    in_weight       <= w;
    in_rate         <= r;
    in_write_value  <= wval;
    in_row_end      <= re;
    // busy sampled here is the pre-edge value the block saw
    do @(posedge clk); while (busy !== 1'b0);
    apply_item(kind, idx, w, r, wval, re);
    items_sent++;
  endtask

  // Q1.15 values biased toward the extremes
  function automatic logic signed [IN_W-1:0] pick_q15();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return IN_W'($urandom);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(9))
      0:             return '0;
      1:             return '1;
      2, 3, 4, 5, 6: return hot_idx[$urandom_range(7)];
      default:       return IDX_W'($urandom_range(NUM_OUT - 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Largest and smallest products, floor rounding of small negatives, both
  // ends of the index range.
  task automatic test_product_extremes();
    idle_pct = 0;
    send_item(REQ_ACC, 12'd0,    16'sh7FFF, 16'sh7FFF, 32'sd0, 1'b1);
    send_item(REQ_ACC, 12'd0,    16'sh8000, 16'sh8000, 32'sd0, 1'b1);
    send_item(REQ_ACC, 12'd0,    16'sh7FFF, 16'sh8000, 32'sd0, 1'b1);
    send_item(REQ_ACC, 12'hFFF,  -16'sd1,   16'sd1,    32'sd0, 1'b1);
    send_item(REQ_ACC, 12'hFFF,  16'sd1,    16'sd1,    32'sd0, 1'b1);
    send_item(REQ_ACC, 12'hFFF,  16'sd0,    16'sh8000, 32'sd0, 1'b0);
    send_item(REQ_READ, 12'hFFF, 16'sd0,    16'sd0,    32'sd0, 1'b0);
  endtask

  // Back-to-back hits on one entry must chain through the RMW loop
  task automatic test_repeated_index();
    idle_pct = 0;
    send_item(REQ_ACC,   12'd7, 16'sh4000, 16'sh7FFF, 32'sd0, 1'b0);
    send_item(REQ_ACC,   12'd7, 16'sh8000, 16'sh1234, 32'sd0, 1'b0);
    send_item(REQ_ACC,   12'd7, 16'sh7FFF, 16'sh7FFF, 32'sd0, 1'b0);
    send_item(REQ_ACC,   12'd7, 16'sh0100, 16'sh8000, 32'sd0, 1'b1);
    send_item(REQ_WRITE, 12'd7, 16'sh7FFF, 16'sh7FFF, 32'sh0001_0000, 1'b1);
    send_item(REQ_READ,  12'd7, 16'sh7FFF, 16'sh7FFF, 32'sh7FFF_FFFF, 1'b1);
    send_item(REQ_ACC,   12'd7, 16'sh8000, 16'sh7FFF, 32'sh7FFF_FFFF, 1'b1);
  endtask

  // Full-scale writes (never touch the flag), reads with the accumulate-only
  // fields set, so row_done must stay low.
  task automatic test_read_write();
    idle_pct = 0;
    send_item(REQ_WRITE, 12'hFFE, 16'sh7FFF, 16'sh7FFF, 32'sh7FFF_FFFF, 1'b1);
    send_item(REQ_READ,  12'hFFE, 16'sh8000, 16'sh8000, 32'sh8000_0000, 1'b1);
    send_item(REQ_WRITE, 12'd1,   16'sd0,    16'sd0,    32'sh8000_0000, 1'b0);
    send_item(REQ_READ,  12'd1,   16'sd0,    16'sd0,    32'sd0,         1'b0);
  endtask

  // Unused request code with row_end set: nothing changes, nothing comes back
  task automatic test_unused_request();
    idle_pct = 0;
    send_item(REQ_UNUSED, 12'd5, 16'sh7FFF, 16'sh7FFF, 32'sh7FFF_FFFF, 1'b1);
    send_item(REQ_READ,   12'd5, 16'sd0,    16'sd0,    32'sd0,         1'b0);
  endtask

  // Clamp at both limits; the flag must stick from here on
  task automatic test_saturation();
    idle_pct = 0;
    send_item(REQ_WRITE, 12'd100, 16'sd0,    16'sd0,    32'sh7FFF_FFF0, 1'b0);
    send_item(REQ_ACC,   12'd100, 16'sh7FFF, 16'sh7FFF, 32'sd0,         1'b1);
    send_item(REQ_WRITE, 12'd101, 16'sd0,    16'sd0,    32'sh8000_0005, 1'b0);
    send_item(REQ_ACC,   12'd101, 16'sh8000, 16'sh7FFF, 32'sd0,         1'b1);
    send_item(REQ_READ,  12'd100, 16'sd0,    16'sd0,    32'sd0,         1'b0);
  endtask

  // Mostly rows of synapses sharing one rate and closed by row_end, mixed
  // with reads, writes, lone accumulates and ignored codes. With full_range
  // low, written values stay small, far from the limits.
  task automatic test_random_traffic(input int n_items, input int pct,
                                     input bit full_range);
    int pick;
    int len;
    int count;
    logic [IDX_W-1:0]       idx;
    logic signed [IN_W-1:0] row_rate;
    logic signed [VAL_W-1:0] wval;
    idle_pct = pct;
    count    = 0;
    while (count < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len      = $urandom_range(1, 10);
        row_rate = pick_q15();
        hot_idx[$urandom_range(7)] = IDX_W'($urandom_range(NUM_OUT - 1));
        idx = pick_index();
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(2) != 0) idx = pick_index();
          send_item(REQ_ACC, idx, pick_q15(), row_rate, $urandom, j == len - 1);
          count++;
        end
      end else if (pick < 75) begin
        send_item(REQ_READ, pick_index(), IN_W'($urandom), IN_W'($urandom),
                  $urandom, 1'($urandom_range(1)));
        count++;
      end else if (pick < 90) begin
        if (!full_range) begin
          wval = $urandom_range(2097151);
          wval = wval - 32'sd1048576;
        end else begin
          case ($urandom_range(3))
            0:       wval = 32'sh7FFF_FFFF - $urandom_range(200000);
            1:       wval = 32'sh8000_0000 + $urandom_range(200000);
            default: wval = $urandom;
          endcase
        end
        send_item(REQ_WRITE, pick_index(), IN_W'($urandom), IN_W'($urandom),
                  wval, 1'($urandom_range(1)));
        count++;
      end else if (pick < 95) begin
        // ignored by the block, so not counted
        send_item(REQ_UNUSED, IDX_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                  $urandom, 1'($urandom_range(1)));
      end else begin
        // stray accumulate outside any row structure
        send_item(REQ_ACC, pick_index(), pick_q15(), pick_q15(), $urandom,
                  1'($urandom_range(1)));
        count++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    foreach (entry_mem[i]) entry_mem[i] = 0;
    foreach (hot_idx[i]) hot_idx[i] = IDX_W'($urandom_range(NUM_OUT - 1));
    sat_flag        = 1'b0;
    idle_pct        = 0;
    items_sent      = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // First item waits out the clearing pass through busy
    test_product_extremes();
    test_repeated_index();
    test_read_write();
    test_unused_request();
    // Flag still clear through the first random phase
    test_random_traffic(175, 0, 1'b0);
    test_saturation();
    test_random_traffic(175, 79, 1'b1);
    test_random_traffic(175, 0, 1'b1);
    test_random_traffic(175, 23, 1'b1);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // results lag behind their items; let any stray one show up
    repeat (DRAIN_PAUSE) @(posedge clk);

    $display("Covered %0d transfers (accumulate rows, reads, writes, unused codes)",
             items_sent);
    $display("Checked %0d results, %0d of them row ends; sticky flag reached: %0b",
             results_checked, rows_closed, sat_flag);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
